### rtl/xie_pkg.sv
`timescale 1ns / 1ps
package xie_pkg;

	localparam int MaxBytes = 10;
	localparam int CntW = 4;

	typedef enum logic [5:0] {
		ACT_MOV_IMM64 = 6'd0,  ACT_MOV_RR = 6'd1,   ACT_ADD_RR = 6'd2,  ACT_ADD_IMM = 6'd3,
		ACT_SUB_RR = 6'd4,     ACT_SUB_IMM = 6'd5,  ACT_MUL = 6'd6,     ACT_DIV = 6'd7,
		ACT_CMP_RR = 6'd8,     ACT_CMP_IMM = 6'd9,  ACT_JMP = 6'd10,    ACT_JE = 6'd11,
		ACT_JNE = 6'd12,       ACT_JG = 6'd13,      ACT_JLE = 6'd14,    ACT_PUSH = 6'd15,
		ACT_POP = 6'd16,       ACT_STORE = 6'd17,   ACT_LOAD = 6'd18,   ACT_LEA = 6'd19,
		ACT_SYSCALL = 6'd20,   ACT_XOR = 6'd21,     ACT_INC = 6'd22,    ACT_DEC = 6'd23,
		ACT_STORE_B = 6'd24,   ACT_TEST = 6'd25,    ACT_JZ8 = 6'd26,    ACT_JNZ8 = 6'd27,
		ACT_NEG = 6'd28,       ACT_JGE = 6'd29,     ACT_SHL = 6'd30,    ACT_SHR = 6'd31,
		ACT_SAR = 6'd32,       ACT_IMUL = 6'd33,    ACT_RET = 6'd34
	} action_t;

	typedef struct packed {
		logic [5:0]  action;
		logic [3:0]  dest_register;
		logic [3:0]  source_register;
		logic [4:0]  base_register;
		logic [3:0]  index_register;
		logic [31:0] displacement;
		logic [63:0] immediate;
		logic [7:0]  shift_count;
	} req_t;

	// decoded form of one instruction, between decode and assembly stages
	typedef struct packed {
		logic        rex_en;      // rex byte present
		logic [7:0]  rex;
		logic        op0_en;      // escape byte 0x0f
		logic        op_en;       // opcode present, clear for unused actions
		logic [7:0]  op;
		logic        modrm_en;
		logic [7:0]  modrm;
		logic        sib_en;
		logic [7:0]  sib;
		logic [3:0]  tail_n;      // bytes of trailing value, 0..8
		logic [63:0] tail;
	} form_t;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [CntW-1:0]          count;
	} code_t;

endpackage

### rtl/xie_stream_if.sv
`timescale 1ns / 1ps
interface xie_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/xie_decode.sv
`timescale 1ns / 1ps
module xie_decode (
	input  xie_pkg::req_t  req,
	output xie_pkg::form_t form
);
	function automatic logic f8(input logic [31:0] v);
		logic [31:0] t;
		begin
			t = v + 32'd128;
			return t < 32'd256;
		end
	endfunction

	logic [2:0] d7, s7, b7;
	logic       dh, sh;
	logic [3:0] b4;
	logic [1:0] mmod;
	logic [7:0] rxw;

	always_comb begin
		d7 = req.dest_register[2:0];
		s7 = req.source_register[2:0];
		dh = req.dest_register[3];
		sh = req.source_register[3];
		b4 = req.base_register[3:0];
		b7 = b4[2:0];
		mmod = (req.displacement == 32'd0 && b7 != 3'd5) ? 2'd0 :
			(f8(req.displacement) ? 2'd1 : 2'd2);
		rxw = 8'h48;
		form = '0;
		form.op_en = 1'b1;
		unique case (req.action)
			xie_pkg::ACT_MOV_IMM64: begin
				form.rex_en = 1'b1; form.rex = rxw | {7'd0, dh};
				form.op = 8'hB8 + {5'd0, d7};
				form.tail_n = 4'd8; form.tail = req.immediate;
			end
			xie_pkg::ACT_MOV_RR, xie_pkg::ACT_ADD_RR, xie_pkg::ACT_SUB_RR,
			xie_pkg::ACT_CMP_RR, xie_pkg::ACT_XOR, xie_pkg::ACT_TEST: begin
				form.rex_en = 1'b1; form.rex = rxw | {5'd0, sh, 1'b0, dh};
				unique case (req.action)
					xie_pkg::ACT_MOV_RR: form.op = 8'h89;
					xie_pkg::ACT_ADD_RR: form.op = 8'h01;
					xie_pkg::ACT_SUB_RR: form.op = 8'h29;
					xie_pkg::ACT_CMP_RR: form.op = 8'h39;
					xie_pkg::ACT_XOR:    form.op = 8'h31;
					default:             form.op = 8'h85;
				endcase
				form.modrm_en = 1'b1; form.modrm = {2'd3, s7, d7};
			end
			xie_pkg::ACT_ADD_IMM, xie_pkg::ACT_SUB_IMM, xie_pkg::ACT_CMP_IMM: begin
				form.rex_en = 1'b1; form.rex = rxw | {7'd0, dh};
				form.tail_n = 4'd4; form.tail = {32'd0, req.immediate[31:0]};
				if (req.dest_register == 4'd0 && req.action != xie_pkg::ACT_CMP_IMM) begin
					form.op = (req.action == xie_pkg::ACT_ADD_IMM) ? 8'h05 : 8'h2D;
				end else begin
					form.op = 8'h81; form.modrm_en = 1'b1;
					unique case (req.action)
						xie_pkg::ACT_ADD_IMM: form.modrm = {2'd3, 3'd0, d7};
						xie_pkg::ACT_SUB_IMM: form.modrm = {2'd3, 3'd5, d7};
						default:              form.modrm = {2'd3, 3'd7, d7};
					endcase
				end
			end
			xie_pkg::ACT_MUL, xie_pkg::ACT_DIV, xie_pkg::ACT_NEG,
			xie_pkg::ACT_INC, xie_pkg::ACT_DEC: begin
				form.rex_en = 1'b1; form.rex = rxw | {7'd0, dh};
				form.modrm_en = 1'b1;
				unique case (req.action)
					xie_pkg::ACT_MUL: begin form.op = 8'hF7; form.modrm = {2'd3, 3'd4, d7}; end
					xie_pkg::ACT_DIV: begin form.op = 8'hF7; form.modrm = {2'd3, 3'd6, d7}; end
					xie_pkg::ACT_NEG: begin form.op = 8'hF7; form.modrm = {2'd3, 3'd3, d7}; end
					xie_pkg::ACT_INC: begin form.op = 8'hFF; form.modrm = {2'd3, 3'd0, d7}; end
					default:          begin form.op = 8'hFF; form.modrm = {2'd3, 3'd1, d7}; end
				endcase
			end
			xie_pkg::ACT_SHL, xie_pkg::ACT_SHR, xie_pkg::ACT_SAR: begin
				form.rex_en = 1'b1; form.rex = rxw | {7'd0, dh};
				form.modrm_en = 1'b1;
				unique case (req.action)
					xie_pkg::ACT_SHL: form.modrm = {2'd3, 3'd4, d7};
					xie_pkg::ACT_SHR: form.modrm = {2'd3, 3'd5, d7};
					default:          form.modrm = {2'd3, 3'd7, d7};
				endcase
				if (req.shift_count == 8'd1) begin
					form.op = 8'hD1;
				end else begin
					form.op = 8'hC1; form.tail_n = 4'd1;
					form.tail = {56'd0, req.shift_count};
				end
			end
			xie_pkg::ACT_JMP: begin
				form.op = 8'hE9; form.tail_n = 4'd4; form.tail = {32'd0, req.displacement};
			end
			xie_pkg::ACT_JE, xie_pkg::ACT_JNE, xie_pkg::ACT_JG, xie_pkg::ACT_JLE,
			xie_pkg::ACT_JGE: begin
				form.op0_en = 1'b1;
				unique case (req.action)
					xie_pkg::ACT_JE:  form.op = 8'h84;
					xie_pkg::ACT_JNE: form.op = 8'h85;
					xie_pkg::ACT_JG:  form.op = 8'h8F;
					xie_pkg::ACT_JLE: form.op = 8'h8E;
					default:          form.op = 8'h8D;
				endcase
				form.tail_n = 4'd4; form.tail = {32'd0, req.displacement};
			end
			xie_pkg::ACT_JZ8, xie_pkg::ACT_JNZ8: begin
				form.op = (req.action == xie_pkg::ACT_JZ8) ? 8'h74 : 8'h75;
				form.tail_n = 4'd1; form.tail = {56'd0, req.displacement[7:0]};
			end
			xie_pkg::ACT_PUSH, xie_pkg::ACT_POP: begin
				form.rex_en = dh; form.rex = 8'h41;
				form.op = ((req.action == xie_pkg::ACT_PUSH) ? 8'h50 : 8'h58) + {5'd0, d7};
			end
			xie_pkg::ACT_STORE, xie_pkg::ACT_LOAD: begin
				form.rex_en = 1'b1; form.modrm_en = 1'b1;
				form.op = (req.action == xie_pkg::ACT_STORE) ? 8'h89 : 8'h8B;
				form.rex = rxw | {5'd0, (req.action == xie_pkg::ACT_STORE) ? sh : dh,
					1'b0, b4[3]};
				form.modrm = {mmod, (req.action == xie_pkg::ACT_STORE) ? s7 : d7, b7};
				form.sib_en = (b7 == 3'd4); form.sib = 8'h24;
				form.tail_n = (mmod == 2'd1) ? 4'd1 : ((mmod == 2'd2) ? 4'd4 : 4'd0);
				form.tail = {32'd0, req.displacement};
			end
			xie_pkg::ACT_LEA: begin
				form.rex_en = 1'b1; form.modrm_en = 1'b1; form.op = 8'h8D;
				form.tail = {32'd0, req.displacement};
				if (req.base_register[4]) begin
					form.rex = rxw | {5'd0, dh, 2'b00};
					form.modrm = {2'd0, d7, 3'd5}; form.tail_n = 4'd4;
				end else begin
					form.rex = rxw | {5'd0, dh, 1'b0, b4[3]};
					form.modrm = {mmod, d7, b7};
					form.sib_en = (b7 == 3'd4); form.sib = 8'h24;
					form.tail_n = (mmod == 2'd1) ? 4'd1 : ((mmod == 2'd2) ? 4'd4 : 4'd0);
				end
			end
			xie_pkg::ACT_STORE_B: begin
				form.rex_en = 1'b1;
				form.rex = rxw | {5'd0, sh, req.index_register[3], b4[3]};
				form.op = 8'h88; form.modrm_en = 1'b1; form.sib_en = 1'b1;
				form.sib = {2'd0, req.index_register[2:0], b7};
				if (b7 == 3'd5) begin
					form.modrm = {2'd1, s7, 3'd4}; form.tail_n = 4'd1;
				end else begin
					form.modrm = {2'd0, s7, 3'd4};
				end
			end
			xie_pkg::ACT_SYSCALL: begin
				form.op0_en = 1'b1; form.op = 8'h05;
			end
			xie_pkg::ACT_IMUL: begin
				form.rex_en = 1'b1; form.rex = rxw | {5'd0, dh, 1'b0, sh};
				form.modrm_en = 1'b1; form.modrm = {2'd3, d7, s7};
				form.tail = {32'd0, req.immediate[31:0]};
				if (f8(req.immediate[31:0])) begin
					form.op = 8'h6B; form.tail_n = 4'd1;
				end else begin
					form.op = 8'h69; form.tail_n = 4'd4;
				end
			end
			xie_pkg::ACT_RET: form.op = 8'hC3;
			default: form = '0;
		endcase
	end
endmodule

### rtl/xie_assemble.sv
`timescale 1ns / 1ps
module xie_assemble (
	input  logic           valid,
	input  xie_pkg::form_t form,
	output xie_pkg::code_t code
);
	logic [xie_pkg::CntW-1:0] n;
	logic [xie_pkg::CntW-1:0] t;

	// pack prefix bytes, then the trailing value little-endian
	always_comb begin
		code = '0;
		n = '0;
		t = '0;
		if (valid) begin
			if (form.rex_en) begin code.bytes[n] = form.rex; n = n + 1'b1; end
			if (form.op0_en) begin code.bytes[n] = 8'h0F; n = n + 1'b1; end
			if (form.op_en) begin code.bytes[n] = form.op; n = n + 1'b1; end
			if (form.modrm_en) begin code.bytes[n] = form.modrm; n = n + 1'b1; end
			if (form.sib_en) begin code.bytes[n] = form.sib; n = n + 1'b1; end
			for (int k = 0; k < 8; k++) begin
				t = n + k[xie_pkg::CntW-1:0];
				if (k[3:0] < form.tail_n && t < xie_pkg::CntW'(xie_pkg::MaxBytes))
					code.bytes[t] = form.tail[k*8 +: 8];
			end
			code.count = n + form.tail_n;
		end
	end
endmodule

### rtl/x86_64_instruction_encoder.sv
`timescale 1ns / 1ps
// x86-64 instruction encoder
// req: one instruction request per item (action code and operands)
// rsp: machine-code bytes, one item each, last_byte set on the final one
// pipeline: s1 registers the request, s2 the decoded form, s3 the packed
// bytes; a serialiser then sends one byte per cycle while rsp.ready is high
// the request passes through s1, s2 and s3 before its first byte is offered on rsp
// throughput: one byte per cycle on rsp while rsp.ready is high, so an
// instruction of 1..10 bytes is sent byte by byte; the byte serialiser
// sets this rate. requests overlap: the pipe keeps taking items while a
// previous instruction is still being sent
// unused action codes give no byte and leave the pipe without delay
// stall: when rsp.ready is low the current byte holds and the stages
// fill up, then req.ready falls; nothing is lost or repeated
// reset: arst_n clears all valid bits and the byte counter
module x86_64_instruction_encoder (
	input logic clk,
	input logic arst_n,
	xie_stream_if.sink   req,
	xie_stream_if.source rsp
);
	logic v_s1, v_s2, v_s3;
	xie_pkg::req_t  r_s1;
	xie_pkg::form_t f_s2, f_c;
	xie_pkg::code_t c_s3, c_c;
	logic [xie_pkg::CntW-1:0] idx_q;
	logic adv1, adv2, adv3, done3;

	xie_decode u_dec (.req(r_s1), .form(f_c));
	xie_assemble u_asm (.valid(1'b1), .form(f_s2), .code(c_c));

	// s3 drains when its last byte goes, or at once when it holds none
	assign done3 = v_s3 && (c_s3.count == '0 ||
		(rsp.ready && idx_q == c_s3.count - 1'b1));
	assign adv3 = !v_s3 || done3;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign req.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; idx_q <= '0;
		end else begin
			if (adv1) v_s1 <= req.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv3) idx_q <= '0;
			else if (rsp.valid && rsp.ready) idx_q <= idx_q + 1'b1;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv1) r_s1 <= req.data;
		if (adv2) f_s2 <= f_c;
		if (adv3) c_s3 <= c_c;
	end

	assign rsp.valid = v_s3 && c_s3.count != '0;
	assign rsp.data.code_byte = c_s3.bytes[idx_q];
	assign rsp.data.last_byte = (idx_q == c_s3.count - 1'b1);
endmodule

### rtl/xie_checker.sv
`timescale 1ns / 1ps
module xie_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_byte,
	input logic       rsp_last
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
		else $error("stalled byte changed");
	a_no_out_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !rsp_valid)
		else $error("byte right after reset");
	// bytes of one instruction follow each other with no gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
		else $error("gap inside an instruction");
	a_req_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> req_ready)
		else $error("not ready after reset");
endmodule

bind x86_64_instruction_encoder xie_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_byte(rsp.data.code_byte), .rsp_last(rsp.data.last_byte)
);
